@@ rtl/scx_pkg.sv @@
// ----------------------------------------------------------------------------
// scx_pkg: shared types and constants of the stream cipher xor engine
// payload structs, configuration register codes and core handshake types
// ----------------------------------------------------------------------------
`default_nettype none

package scx_pkg;

  localparam int ROUNDS_DEFAULT      = 20;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register codes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_PART_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_START = 3'd5;

  typedef struct packed {
    logic [7:0] data_in;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       end_of_message_out;
  } out_t;

  // key and nonce as seen by the core
  typedef struct packed {
    logic [63:0] key_part_0;
    logic [63:0] key_part_1;
    logic [63:0] key_part_2;
    logic [63:0] key_part_3;
    logic [63:0] nonce_value;
  } cfg_t;

  // a configuration transfer to a known register
  typedef struct packed {
    logic        hit;
    logic [63:0] counter;
  } cfg_evt_t;

  typedef logic [15:0][31:0] block_t;

  typedef struct packed {
    logic        start;
    logic        abort;
    logic        take;
    logic [63:0] counter;
  } core_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_FIN,
    CORE_DONE
  } core_state_t;

endpackage

`default_nettype wire

@@ rtl/scx_front.sv @@
// ----------------------------------------------------------------------------
// scx_front: input byte queue
// accepts byte transfers and holds them until the back end takes them
// ----------------------------------------------------------------------------
`default_nettype none

module scx_front #(
  parameter int DEPTH = scx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push_valid,
  output logic             push_ready,
  input  wire scx_pkg::in_t push_item,
  output logic             pop_valid,
  input  wire logic        pop_ready,
  output scx_pkg::in_t     pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  scx_pkg::in_t   slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scx_core.sv @@
// ----------------------------------------------------------------------------
// scx_core: keystream block generator
// iterative salsa core, half a round per cycle, then feed-forward addition
// ----------------------------------------------------------------------------
`default_nettype none

module scx_core #(
  parameter int ROUNDS = scx_pkg::ROUNDS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scx_pkg::cfg_t      cfg,
  input  wire scx_pkg::core_req_t req,
  output scx_pkg::core_stat_t     stat,
  output scx_pkg::block_t         block
);

  localparam int RW = $clog2(ROUNDS);
  localparam logic [RW-1:0] LAST_ROUND = RW'(ROUNDS - 1);

  // quarter-round word indexes a, b, c, d
  localparam logic [3:0] COL_IDX [4][4] = '{
    '{4'd0,  4'd4,  4'd8,  4'd12},
    '{4'd5,  4'd9,  4'd13, 4'd1},
    '{4'd10, 4'd14, 4'd2,  4'd6},
    '{4'd15, 4'd3,  4'd7,  4'd11}
  };
  localparam logic [3:0] ROW_IDX [4][4] = '{
    '{4'd0,  4'd1,  4'd2,  4'd3},
    '{4'd5,  4'd6,  4'd7,  4'd4},
    '{4'd10, 4'd11, 4'd8,  4'd9},
    '{4'd15, 4'd12, 4'd13, 4'd14}
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic scx_pkg::block_t init_block(input scx_pkg::cfg_t c,
                                                 input logic [63:0] ctr);
    scx_pkg::block_t b;
    b[0]  = 32'h61707865;
    b[5]  = 32'h3320646e;
    b[10] = 32'h79622d32;
    b[15] = 32'h6b206574;
    b[1]  = c.key_part_0[31:0];
    b[2]  = c.key_part_0[63:32];
    b[3]  = c.key_part_1[31:0];
    b[4]  = c.key_part_1[63:32];
    b[11] = c.key_part_2[31:0];
    b[12] = c.key_part_2[63:32];
    b[13] = c.key_part_3[31:0];
    b[14] = c.key_part_3[63:32];
    b[6]  = c.nonce_value[31:0];
    b[7]  = c.nonce_value[63:32];
    b[8]  = ctr[31:0];
    b[9]  = ctr[63:32];
    return b;
  endfunction

  scx_pkg::core_state_t state;
  scx_pkg::core_state_t state_next;
  scx_pkg::block_t      w;
  scx_pkg::block_t      round_out;
  scx_pkg::block_t      init_words;
  logic [63:0]          counter;
  logic [RW-1:0]        round_cnt;
  logic                 half;

  assign stat.idle  = (state == scx_pkg::CORE_IDLE);
  assign stat.done  = (state == scx_pkg::CORE_DONE);
  assign block      = w;
  assign init_words = init_block(cfg, (state == scx_pkg::CORE_IDLE) ? req.counter : counter);

  // half 0: steps on b and c, half 1: steps on d and a
  always_comb begin
    logic [3:0]  ia;
    logic [3:0]  ib;
    logic [3:0]  ic;
    logic [3:0]  id;
    logic [31:0] t0;
    logic [31:0] t1;
    round_out = w;
    for (int q = 0; q < 4; q++) begin
      ia = round_cnt[0] ? ROW_IDX[q][0] : COL_IDX[q][0];
      ib = round_cnt[0] ? ROW_IDX[q][1] : COL_IDX[q][1];
      ic = round_cnt[0] ? ROW_IDX[q][2] : COL_IDX[q][2];
      id = round_cnt[0] ? ROW_IDX[q][3] : COL_IDX[q][3];
      if (!half) begin
        t0 = w[ib] ^ rotl(w[ia] + w[id], 7);
        t1 = w[ic] ^ rotl(t0 + w[ia], 9);
        round_out[ib] = t0;
        round_out[ic] = t1;
      end else begin
        t0 = w[id] ^ rotl(w[ic] + w[ib], 13);
        t1 = w[ia] ^ rotl(t0 + w[ic], 18);
        round_out[id] = t0;
        round_out[ia] = t1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scx_pkg::CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      scx_pkg::CORE_IDLE: begin
        if (req.start) state_next = scx_pkg::CORE_RUN;
      end
      scx_pkg::CORE_RUN: begin
        if (half && round_cnt == LAST_ROUND) state_next = scx_pkg::CORE_FIN;
      end
      scx_pkg::CORE_FIN: begin
        state_next = scx_pkg::CORE_DONE;
      end
      scx_pkg::CORE_DONE: begin
        if (req.take) state_next = scx_pkg::CORE_IDLE;
      end
    endcase
    if (req.abort) state_next = scx_pkg::CORE_IDLE;
  end

  always_ff @(posedge clk) begin
    case (state)
      scx_pkg::CORE_IDLE: begin
        w         <= init_words;
        counter   <= req.counter;
        round_cnt <= '0;
        half      <= 1'b0;
      end
      scx_pkg::CORE_RUN: begin
        w    <= round_out;
        half <= ~half;
        if (half) round_cnt <= round_cnt + 1'b1;
      end
      scx_pkg::CORE_FIN: begin
        for (int i = 0; i < 16; i++) begin
          w[i] <= w[i] + init_words[i];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/scx_back.sv @@
// ----------------------------------------------------------------------------
// scx_back: keystream buffer and xor stage
// holds the current block, position and counter, drives the output register
// ----------------------------------------------------------------------------
`default_nettype none

module scx_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire scx_pkg::in_t        q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output scx_pkg::out_t            out_item,
  input  wire scx_pkg::cfg_evt_t   cfg_evt,
  output scx_pkg::core_req_t       core_req,
  input  wire scx_pkg::core_stat_t core_stat,
  input  wire scx_pkg::block_t     core_block
);

  scx_pkg::block_t cur_words;
  logic            cur_valid;
  logic [5:0]      byte_pos;
  logic [63:0]     block_counter;
  logic [31:0]     ks_word;
  logic [7:0]      ks_byte;
  logic            pop;
  logic            block_end;
  logic            load;

  assign ks_word   = cur_words[byte_pos[5:2]];
  assign ks_byte   = 8'(ks_word >> {byte_pos[1:0], 3'b000});
  assign q_ready   = cur_valid && (!out_valid || out_ready);
  assign pop       = q_valid && q_ready;
  assign block_end = pop && (byte_pos == 6'd63 || q_item.end_of_message);
  assign load      = core_stat.done && (!cur_valid || block_end);

  // the core works on the block after the one in use, or on the block at block_counter while none is held
  assign core_req.start   = core_stat.idle && !cfg_evt.hit;
  assign core_req.abort   = cfg_evt.hit;
  assign core_req.take    = load;
  assign core_req.counter = block_counter + {63'd0, cur_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      byte_pos      <= '0;
      block_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (pop) begin
        out_valid <= 1'b1;
        byte_pos  <= block_end ? 6'd0 : byte_pos + 6'd1;
      end
      if (block_end) begin
        block_counter <= block_counter + 64'd1;
        cur_valid     <= 1'b0;
      end
      if (load) cur_valid <= 1'b1;
      if (cfg_evt.hit) begin
        block_counter <= cfg_evt.counter;
        byte_pos      <= '0;
        cur_valid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_words <= core_block;
    if (pop) begin
      out_item.data_out           <= q_item.data_in ^ ks_byte;
      out_item.end_of_message_out <= q_item.end_of_message;
    end
  end

endmodule

`default_nettype wire

@@ rtl/stream_cipher_xor_engine.sv @@
// ----------------------------------------------------------------------------
// stream_cipher_xor_engine: salsa20 keystream xor engine
// xors each byte with the salsa20 keystream; key, nonce and counter set by
// configuration writes
// ----------------------------------------------------------------------------
// Each input transfer carries one byte and an end-of-message flag; each
// produces exactly one output transfer with the byte xored by the next
// keystream byte, by way of the input queue and the output register.
// Keystream comes from an iterative core that builds each 64-byte block
// in steps (load, two half rounds per round, feed-forward, hand-over). It
// builds the next block while the current one is used, so a full 64-byte
// block streams at one byte per cycle when nothing stalls, with no gap at
// the block boundary. An end of message throws the rest of the block away,
// and the core starts the following block only once the block ahead has
// been handed over: when a message ends before the core has finished the
// following block, the next byte waits for the core, and a stream of
// one-byte messages moves on one byte per finished block. After reset and
// after every write to a known register the first byte waits for its block
// to be built. Configuration writes are taken in any cycle; writes to
// unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_cipher_xor_engine #(
  parameter int ROUNDS      = scx_pkg::ROUNDS_DEFAULT,
  parameter int QUEUE_DEPTH = scx_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // byte input
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire scx_pkg::in_t                   in_item,
  // byte output
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output scx_pkg::out_t                       out_item,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [scx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [scx_pkg::CFG_DATA_W-1:0] cfg_data
);

  scx_pkg::cfg_t       cfg;
  logic [63:0]         counter_start;
  logic [63:0]         counter_start_next;
  logic                cfg_write;
  logic                cfg_known;
  scx_pkg::cfg_evt_t   cfg_evt;
  logic                q_valid;
  logic                q_ready;
  scx_pkg::in_t        q_item;
  scx_pkg::core_req_t  core_req;
  scx_pkg::core_stat_t core_stat;
  scx_pkg::block_t     core_block;

  // configuration is never back-pressured
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // decode the register index; unknown codes leave everything alone
  always_comb begin
    cfg_known          = 1'b1;
    counter_start_next = counter_start;
    unique case (cfg_index)
      scx_pkg::REG_KEY_PART_0,
      scx_pkg::REG_KEY_PART_1,
      scx_pkg::REG_KEY_PART_2,
      scx_pkg::REG_KEY_PART_3,
      scx_pkg::REG_NONCE_VALUE: begin
      end
      scx_pkg::REG_COUNTER_START: begin
        counter_start_next = cfg_data;
      end
      default: begin
        cfg_known = 1'b0;
      end
    endcase
  end

  // a known write reloads the counter and drops any keystream in hand
  assign cfg_evt.hit     = cfg_write && cfg_known;
  assign cfg_evt.counter = counter_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg           <= '0;
      counter_start <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scx_pkg::REG_KEY_PART_0:    cfg.key_part_0  <= cfg_data;
        scx_pkg::REG_KEY_PART_1:    cfg.key_part_1  <= cfg_data;
        scx_pkg::REG_KEY_PART_2:    cfg.key_part_2  <= cfg_data;
        scx_pkg::REG_KEY_PART_3:    cfg.key_part_3  <= cfg_data;
        scx_pkg::REG_NONCE_VALUE:   cfg.nonce_value <= cfg_data;
        scx_pkg::REG_COUNTER_START: counter_start   <= counter_start_next;
        default: begin
        end
      endcase
    end
  end

  // front: byte queue between the input port and the xor stage
  scx_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (in_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // back: keystream buffer, position and counter, output register
  scx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .cfg_evt    (cfg_evt),
    .core_req   (core_req),
    .core_stat  (core_stat),
    .core_block (core_block)
  );

  // keystream core, runs one block ahead of the back end while the back end holds a block
  scx_core #(
    .ROUNDS (ROUNDS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .req   (core_req),
    .stat  (core_stat),
    .block (core_block)
  );

endmodule

`default_nettype wire

@@ bench/tb_stream_cipher_xor_engine.sv @@
// ----------------------------------------------------------------------------
// tb_stream_cipher_xor_engine: self-checking bench for the salsa20 xor engine
// a scoreboard runs its own salsa20 keystream predictor next to the engine,
// with directed key, counter and register-index cases followed by random
// messages under several sender and receiver idle patterns
// ----------------------------------------------------------------------------
module tb_stream_cipher_xor_engine;

  localparam int NUM_ROUNDS  = scx_pkg::ROUNDS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;

  // indexes with no register behind them, writes there must be dropped
  localparam logic [scx_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_6 = 3'd6;
  localparam logic [scx_pkg::CFG_IDX_W-1:0] REG_UNKNOWN_7 = 3'd7;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  typedef logic [15:0][31:0] keyblock_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  scx_pkg::in_t                   in_item   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  scx_pkg::out_t                  out_item;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [scx_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scx_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  // idle pattern of the current phase, in percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  // scoreboard: keystream-xored bytes still to come out, oldest first
  scx_pkg::out_t expected_bytes[$];

  // predictor copy of the register file and keystream state
  logic [63:0] key_part [4];
  logic [63:0] nonce_reg;
  logic [63:0] ctr_start;
  keyblock_t   ks_block;
  logic [5:0]  ks_pos;
  logic [63:0] blk_ctr;
  logic        ks_held;

  initial begin
    for (int k = 0; k < 4; k++) key_part[k] = '0;
    nonce_reg = '0;
    ctr_start = '0;
    ks_block  = '0;
    ks_pos    = '0;
    blk_ctr   = '0;
    ks_held   = 1'b0;
  end

  stream_cipher_xor_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // salsa20 keystream predictor
  // --------------------------------------------------------------------------

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic keyblock_t quarter_mix(input keyblock_t w, input int a, input int b,
                                            input int c, input int d);
    w[b] = w[b] ^ rotl(w[a] + w[d], 7);
    w[c] = w[c] ^ rotl(w[b] + w[a], 9);
    w[d] = w[d] ^ rotl(w[c] + w[b], 13);
    w[a] = w[a] ^ rotl(w[d] + w[c], 18);
    return w;
  endfunction

  function automatic keyblock_t column_pass(input keyblock_t w);
    w = quarter_mix(w, 0, 4, 8, 12);
    w = quarter_mix(w, 5, 9, 13, 1);
    w = quarter_mix(w, 10, 14, 2, 6);
    w = quarter_mix(w, 15, 3, 7, 11);
    return w;
  endfunction

  function automatic keyblock_t row_pass(input keyblock_t w);
    w = quarter_mix(w, 0, 1, 2, 3);
    w = quarter_mix(w, 5, 6, 7, 4);
    w = quarter_mix(w, 10, 11, 8, 9);
    w = quarter_mix(w, 15, 12, 13, 14);
    return w;
  endfunction

  // one 64-byte keystream block for the current key, nonce and counter
  function automatic keyblock_t salsa_block(input logic [63:0] ctr);
    keyblock_t init;
    keyblock_t w;
    int        r;
    init[0]  = SIGMA_0;
    init[5]  = SIGMA_1;
    init[10] = SIGMA_2;
    init[15] = SIGMA_3;
    init[1]  = key_part[0][31:0];
    init[2]  = key_part[0][63:32];
    init[3]  = key_part[1][31:0];
    init[4]  = key_part[1][63:32];
    init[11] = key_part[2][31:0];
    init[12] = key_part[2][63:32];
    init[13] = key_part[3][31:0];
    init[14] = key_part[3][63:32];
    init[6]  = nonce_reg[31:0];
    init[7]  = nonce_reg[63:32];
    init[8]  = ctr[31:0];
    init[9]  = ctr[63:32];
    w = init;
    for (r = 0; r + 1 < NUM_ROUNDS; r += 2) begin
      w = row_pass(column_pass(w));
    end
    // an odd round count ends on a lone column round
    if (r < NUM_ROUNDS) begin
      w = column_pass(w);
    end
    for (int i = 0; i < 16; i++) begin
      w[i] = w[i] + init[i];
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // monitor and scoreboard: register writes, byte transfers in, bytes out
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    logic          known;
    logic [7:0]    ks_byte;
    scx_pkg::out_t predicted;
    scx_pkg::out_t oldest;
    if (!rst) begin
      // register write first, the bench never overlaps it with byte traffic
      if (cfg_valid && cfg_ready) begin
        known = 1'b1;
        case (cfg_index)
          scx_pkg::REG_KEY_PART_0:    key_part[0] = cfg_data;
          scx_pkg::REG_KEY_PART_1:    key_part[1] = cfg_data;
          scx_pkg::REG_KEY_PART_2:    key_part[2] = cfg_data;
          scx_pkg::REG_KEY_PART_3:    key_part[3] = cfg_data;
          scx_pkg::REG_NONCE_VALUE:   nonce_reg   = cfg_data;
          scx_pkg::REG_COUNTER_START: ctr_start   = cfg_data;
          default:                    known       = 1'b0;
        endcase
        // any known write restarts the stream from counter_start
        if (known) begin
          blk_ctr = ctr_start;
          ks_pos  = '0;
          ks_held = 1'b0;
        end
      end

      if (in_valid && in_ready) begin
        if (!ks_held) begin
          ks_block = salsa_block(blk_ctr);
          ks_held  = 1'b1;
        end
        ks_byte = ks_block[ks_pos[5:2]][ks_pos[1:0] * 8 +: 8];
        predicted.data_out           = in_item.data_in ^ ks_byte;
        predicted.end_of_message_out = in_item.end_of_message;
        expected_bytes.push_back(predicted);
        // leftover keystream is dropped at a message end, counter wraps at 2^64
        if (ks_pos == 6'd63 || in_item.end_of_message) begin
          blk_ctr = blk_ctr + 64'd1;
          ks_pos  = '0;
          ks_held = 1'b0;
        end else begin
          ks_pos = ks_pos + 6'd1;
        end
      end

      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output transfer, expected none, got %h", $time, out_item);
          fail_count++;
        end else begin
          oldest = expected_bytes.pop_front();
          if (out_item.data_out !== oldest.data_out) begin
            $display("%0t: data_out mismatch, expected %h, got %h",
                     $time, oldest.data_out, out_item.data_out);
            fail_count++;
          end
          if (out_item.end_of_message_out !== oldest.end_of_message_out) begin
            $display("%0t: end_of_message_out mismatch, expected %b, got %b",
                     $time, oldest.end_of_message_out, out_item.end_of_message_out);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver backpressure, one fresh draw every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // offer one byte, with a random idle gap in front, and return at the edge
  // where it is transferred; valid stays up so a following byte can go
  // back to back
  task automatic send_byte(input logic [7:0] value, input logic last);
    if (cfg_valid) cfg_valid <= 1'b0;
    if ($urandom_range(99) < send_idle_pct) begin
      if (in_valid) in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= {value, last};
    do @(posedge clk); while (!in_ready);
  endtask

  // drop all valids and wait until every predicted byte has come out
  task automatic wait_drained();
    if (in_valid) in_valid <= 1'b0;
    if (cfg_valid) cfg_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // one register write; call only with the engine drained
  task automatic write_reg(input logic [scx_pkg::CFG_IDX_W-1:0] index,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // register value leaning on the extremes now and then
  function automatic logic [63:0] pick_reg_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset values only: all-zero key, nonce and counter
  task automatic test_zero_key();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b1);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // every register all ones; counter at its top value wraps to zero after
  // the first message end
  task automatic test_all_ones_wrap();
    wait_drained();
    write_reg(scx_pkg::REG_KEY_PART_0, '1);
    write_reg(scx_pkg::REG_KEY_PART_1, '1);
    write_reg(scx_pkg::REG_KEY_PART_2, '1);
    write_reg(scx_pkg::REG_KEY_PART_3, '1);
    write_reg(scx_pkg::REG_NONCE_VALUE, '1);
    write_reg(scx_pkg::REG_COUNTER_START, '1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  // writes to unused indexes leave a message running; a known write in the
  // middle of a message starts over from counter_start at byte zero
  task automatic test_register_index();
    wait_drained();
    write_reg(scx_pkg::REG_KEY_PART_0, {$urandom, $urandom});
    write_reg(scx_pkg::REG_COUNTER_START, '0);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    write_reg(REG_UNKNOWN_6, {$urandom, $urandom});
    write_reg(REG_UNKNOWN_7, '1);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b0);
    wait_drained();
    write_reg(scx_pkg::REG_NONCE_VALUE, {$urandom, $urandom});
    send_byte(8'($urandom_range(255)), 1'b0);
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // fresh settings, then random messages; mostly short ones, some crossing
  // one or more 64-byte blocks, a few without an end flag so they run on
  task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
    int sent;
    int len;
    int pick;
    int i;
    bit paused;
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(scx_pkg::REG_KEY_PART_0, pick_reg_value());
    write_reg(scx_pkg::REG_KEY_PART_1, pick_reg_value());
    write_reg(scx_pkg::REG_KEY_PART_2, pick_reg_value());
    write_reg(scx_pkg::REG_KEY_PART_3, pick_reg_value());
    write_reg(scx_pkg::REG_NONCE_VALUE, pick_reg_value());
    write_reg(scx_pkg::REG_COUNTER_START, pick_reg_value());
    if ($urandom_range(1) == 0) begin
      write_reg($urandom_range(1) ? REG_UNKNOWN_6 : REG_UNKNOWN_7, {$urandom, $urandom});
    end
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len = $urandom_range(12, 1);
      end else if (pick < 95) begin
        len = $urandom_range(80, 13);
      end else begin
        len = $urandom_range(200, 81);
      end
      for (i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), (i == len - 1) && ($urandom_range(99) < 85));
      end
      sent += len;
      // sender holds off once until the pipeline is empty
      if (!paused && sent >= n_items / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_zero_key();
    test_all_ones_wrap();
    test_register_index();
    test_random_phase(0, 0, 350);
    test_random_phase(84, 0, 350);
    test_random_phase(0, 84, 350);
    test_random_phase(25, 25, 350);

    // let a stray late transfer show up before the verdict
    wait_drained();
    repeat (2 * NUM_ROUNDS + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/scx_pkg.sv
rtl/scx_front.sv
rtl/scx_core.sv
rtl/scx_back.sv
rtl/stream_cipher_xor_engine.sv
bench/tb_stream_cipher_xor_engine.sv
